// ----- design/sha384_pkg.sv -----
// ============================================================================
// sha384_pkg
// Shared types, constants and round functions of the SHA-384 engine.
// ============================================================================
package sha384_pkg;

    localparam int WORD_W     = 64;
    localparam int BLK_WORDS  = 16;
    localparam int HASH_WORDS = 8;
    localparam int DIG_WORDS  = 6;
    localparam int ROUNDS     = 80;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT,
        ST_OWAIT
    } state_t;

    function automatic word_t iv_word(input logic [2:0] i);
        word_t r;
        r = '0;
        unique case (i)
            3'd0: r = 64'hcbbb9d5dc1059ed8;
            3'd1: r = 64'h629a292a367cd507;
            3'd2: r = 64'h9159015a3070dd17;
            3'd3: r = 64'h152fecd8f70e5939;
            3'd4: r = 64'h67332667ffc00b31;
            3'd5: r = 64'h8eb44a8768581511;
            3'd6: r = 64'hdb0c2e0d64f98fa7;
            3'd7: r = 64'h47b5481dbefa4fa4;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic word_t rk_word(input logic [6:0] t);
        word_t k [ROUNDS];
        k = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
        return (t < 7'(ROUNDS)) ? k[t] : '0;
    endfunction

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

// ----- design/sha384_ram.sv -----
// ============================================================================
// sha384_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module sha384_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/sha384_hash_engine.sv -----
// ============================================================================
// sha384_hash_engine
// Streaming SHA-384: bytes in, six 64-bit digest words out.
// ============================================================================
// Input channel (in_valid/in_ready): one transaction carries data_byte,
// byte_valid and msg_end. Bytes pack big-endian into a 16-word block memory.
// Output channel (out_valid/out_ready): six transactions per message, most
// significant digest word first, word_last on the sixth.
// A byte that does not complete a block leaves in_ready high. A full block
// runs the compression with in_ready low: it loads the working registers
// from the chain memory, runs 16 rounds on word t as read ahead, then 64
// rounds of three schedule reads followed by the round, and folds the
// result into the chain memory.
// A final item adds 0x80, zero fill and the 128-bit length one byte a cycle
// up to the end of the block, then one compression, or two when the length
// does not fit, then the six output transactions.
// Reset: the chain memory is not cleared; a per-message flag makes the first
// block load the SHA-384 initial hash instead of the chain memory.
// When the receiver stalls, the engine holds the current digest word and
// accepts no input until all six are taken.
// ============================================================================
module sha384_hash_engine
    import sha384_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        msg_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic        word_last
);
    state_t state_reg, state_next;
    logic [6:0]  fill_reg, fill_next;
    logic [63:0] nbytes_reg, nbytes_next;
    logic [63:0] bits_reg, bits_next;
    logic        fin_reg, fin_next;          // padding phase of a final item
    logic        pend80_reg, pend80_next;    // 0x80 not placed yet
    logic        two_blk_reg, two_blk_next;  // length goes in the following block
    logic        fresh_reg, fresh_next;      // chain memory holds no valid hash
    logic [6:0]  rnd_reg, rnd_next;
    logic [1:0]  sub_reg, sub_next;
    logic [3:0]  cnt_reg, cnt_next;
    word_t       wacc_reg, wacc_next;        // word under assembly
    word_t       sacc_reg, sacc_next;        // schedule partial sum
    word_t       va_reg [HASH_WORDS];
    word_t       va_next [HASH_WORDS];
    logic        out_v_reg, out_v_next;
    word_t       dout_reg, dout_next;
    logic        last_reg, last_next;
    logic [2:0]  c_ra_reg;

    // block memory
    logic       b_we;
    logic [3:0] b_wa, b_ra;
    word_t      b_wd, b_rd;
    // chain memory
    logic       c_we;
    logic [2:0] c_wa, c_ra;
    word_t      c_wd, c_rd;

    sha384_ram #(.WIDTH(WORD_W), .DEPTH(BLK_WORDS)) u_blk (
        .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
    sha384_ram #(.WIDTH(WORD_W), .DEPTH(HASH_WORDS)) u_chn (
        .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

    word_t chain_rd;
    assign chain_rd = fresh_reg ? iv_word(c_ra_reg) : c_rd;

    logic [2:0] cnt_m1;
    assign cnt_m1 = cnt_reg[2:0] - 3'd1;

    logic [6:0] rnd_inc;
    assign rnd_inc = rnd_reg + 7'd1;

    // byte to push this cycle
    logic       push_en;
    logic [7:0] push_byte;

    // round datapath; w is split in two parts so it folds into the t1 sum
    word_t g0, g1, w_a, w_b, w_t, s1, ch, t1, s0, mj;
    always_comb
    begin
        g0  = ror(b_rd, 1) ^ ror(b_rd, 8) ^ (b_rd >> 7);
        g1  = ror(b_rd, 19) ^ ror(b_rd, 61) ^ (b_rd >> 6);
        w_a = (rnd_reg < 7'd16) ? b_rd : sacc_reg;
        w_b = (rnd_reg < 7'd16) ? '0 : g1;
        w_t = w_a + w_b;
        s1  = ror(va_reg[4], 14) ^ ror(va_reg[4], 18) ^ ror(va_reg[4], 41);
        ch  = (va_reg[4] & va_reg[5]) ^ (~va_reg[4] & va_reg[6]);
        t1  = va_reg[7] + s1 + ch + rk_word(rnd_reg) + w_a + w_b;
        s0  = ror(va_reg[0], 28) ^ ror(va_reg[0], 34) ^ ror(va_reg[0], 39);
        mj  = (va_reg[0] & va_reg[1]) ^ (va_reg[0] & va_reg[2]) ^ (va_reg[1] & va_reg[2]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_valid)
                begin
                    if (byte_valid && fill_reg == 7'd127)
                        state_next = ST_LOAD;
                    else if (msg_end)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 7'd127)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (cnt_reg == 4'd8)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg == 7'(ROUNDS - 1) && sub_reg == 2'd3)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                // non-final block: back to fill; padding still pending after this block: run another one; else output
                if (cnt_reg == 4'd8)
                begin
                    if (!fin_reg)
                        state_next = ST_FILL;
                    else if (pend80_reg || two_blk_reg)
                        state_next = ST_PAD;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_OWAIT;
            end
            ST_OWAIT:
            begin
                if (out_v_reg && out_ready)
                    state_next = (cnt_reg == 4'(DIG_WORDS - 1)) ? ST_FILL : ST_OUT;
            end
            default: state_next = ST_FILL;
        endcase
    end

    assign in_ready    = (state_reg == ST_FILL);
    assign out_valid   = out_v_reg;
    assign digest_word = dout_reg;
    assign word_last   = last_reg;

    // datapath and memory control
    always_comb
    begin
        fill_next = fill_reg; nbytes_next = nbytes_reg; bits_next = bits_reg;
        fin_next = fin_reg; pend80_next = pend80_reg; two_blk_next = two_blk_reg;
        fresh_next = fresh_reg; rnd_next = rnd_reg; sub_next = sub_reg;
        cnt_next = cnt_reg; wacc_next = wacc_reg; sacc_next = sacc_reg;
        out_v_next = out_v_reg; dout_next = dout_reg; last_next = last_reg;
        for (int i = 0; i < HASH_WORDS; i++) va_next[i] = va_reg[i];
        b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
        c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
        push_en = 1'b0; push_byte = 8'h00;
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        push_en = 1'b1; push_byte = data_byte;
                        nbytes_next = nbytes_reg + 64'd1;
                    end
                    if (msg_end)
                    begin
                        fin_next = 1'b1; pend80_next = 1'b1; two_blk_next = 1'b0;
                        bits_next = (byte_valid ? nbytes_reg + 64'd1 : nbytes_reg) << 3;
                    end
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (pend80_reg)
                begin
                    push_byte = 8'h80; pend80_next = 1'b0;
                    // no room left for the length in this block
                    if (fill_reg >= 7'd112)
                        two_blk_next = 1'b1;
                end
                else if (!two_blk_reg && fill_reg >= 7'd120)
                    push_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
            end
            ST_LOAD:
            begin
                c_ra = cnt_reg[2:0];
                if (cnt_reg != 4'd0)
                    va_next[cnt_m1] = chain_rd;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    cnt_next = '0; rnd_next = '0; sub_next = 2'd3;
                    b_ra = '0;
                end
            end
            ST_ROUND:
            begin
                // sub 0: take old word t, read t-15; sub 1: add g0, read t-7;
                // sub 2: add word t-7, read t-2; sub 3: add g1 and run the round.
                // Rounds below 16 use word t as read and stay in sub 3.
                unique case (sub_reg)
                    2'd0:
                    begin
                        sacc_next = b_rd; b_ra = rnd_reg[3:0] - 4'd15; sub_next = 2'd1;
                    end
                    2'd1:
                    begin
                        sacc_next = sacc_reg + g0; b_ra = rnd_reg[3:0] - 4'd7; sub_next = 2'd2;
                    end
                    2'd2:
                    begin
                        sacc_next = sacc_reg + b_rd; b_ra = rnd_reg[3:0] - 4'd2;
                        sub_next = 2'd3;
                    end
                    2'd3:
                    begin
                        if (rnd_reg >= 7'd16)
                        begin
                            b_we = 1'b1; b_wa = rnd_reg[3:0]; b_wd = w_t;
                        end
                        va_next[7] = va_reg[6]; va_next[6] = va_reg[5]; va_next[5] = va_reg[4];
                        va_next[4] = va_reg[3] + t1; va_next[3] = va_reg[2];
                        va_next[2] = va_reg[1]; va_next[1] = va_reg[0];
                        va_next[0] = t1 + s0 + mj;
                        rnd_next = rnd_inc;
                        b_ra = rnd_inc[3:0];
                        sub_next = (rnd_inc >= 7'd16) ? 2'd0 : 2'd3;
                        if (rnd_reg == 7'(ROUNDS - 1))
                        begin
                            rnd_next = '0; cnt_next = '0; sub_next = 2'd3;
                        end
                    end
                endcase
            end
            ST_ADD:
            begin
                c_ra = cnt_reg[2:0];
                if (cnt_reg != 4'd0)
                begin
                    c_we = 1'b1; c_wa = cnt_m1;
                    c_wd = chain_rd + va_reg[cnt_m1];
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    cnt_next = '0; fresh_next = 1'b0;
                    if (fin_reg)
                        two_blk_next = 1'b0;
                end
            end
            ST_OUT:
            begin
                c_ra = cnt_reg[2:0];
            end
            ST_OWAIT:
            begin
                c_ra = cnt_reg[2:0];
                if (!out_v_reg)
                begin
                    out_v_next = 1'b1; dout_next = c_rd;
                    last_next = (cnt_reg == 4'(DIG_WORDS - 1));
                end
                else if (out_ready)
                begin
                    out_v_next = 1'b0;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'(DIG_WORDS - 1))
                    begin
                        cnt_next = '0; fresh_next = 1'b1; fin_next = 1'b0;
                        nbytes_next = '0; fill_next = '0;
                    end
                end
            end
            default: ;
        endcase
        if (push_en)
        begin
            wacc_next = ((fill_reg[2:0] == 3'd0) ? '0 : wacc_reg)
                      | (word_t'(push_byte) << {~fill_reg[2:0], 3'b000});
            b_we = 1'b1; b_wa = fill_reg[6:3]; b_wd = wacc_next;
            fill_next = fill_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL; fill_reg <= '0; nbytes_reg <= '0; bits_reg <= '0;
            fin_reg <= 1'b0; pend80_reg <= 1'b0; two_blk_reg <= 1'b0; fresh_reg <= 1'b1;
            rnd_reg <= '0; sub_reg <= '0; cnt_reg <= '0; wacc_reg <= '0; sacc_reg <= '0;
            out_v_reg <= 1'b0; dout_reg <= '0; last_reg <= 1'b0; c_ra_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; fill_reg <= fill_next; nbytes_reg <= nbytes_next;
            bits_reg <= bits_next; fin_reg <= fin_next; pend80_reg <= pend80_next;
            two_blk_reg <= two_blk_next; fresh_reg <= fresh_next; rnd_reg <= rnd_next;
            sub_reg <= sub_next; cnt_reg <= cnt_next; wacc_reg <= wacc_next;
            sacc_reg <= sacc_next; out_v_reg <= out_v_next; dout_reg <= dout_next;
            last_reg <= last_next; c_ra_reg <= c_ra;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HASH_WORDS; i++) va_reg[i] <= va_next[i];
    end
endmodule

// ----- tb/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the streaming SHA-384 engine.
// ============================================================================
// Bytes go in one transaction at a time, with random gaps on the input side.
// Digest words come out with random stalls on the output side. A predictor
// inside the bench hashes the same messages and queues six expected words
// per message. Each accepted digest word is checked against the oldest one.
// The directed part is a table of stimulus, walked by a loop. The random part
// follows it and is checked the same way.
// ============================================================================
module tb;

    // Clock, reset and the ports of the block.
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        msg_end;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_word;
    logic        word_last;

    // One input transaction.
    typedef struct packed {
        logic [7:0] data;
        logic       bv;
        logic       last;
    } byte_item_t;

    // One expected digest word.
    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } digest_exp_t;

    // Predictor state: chaining words, block buffer, fill and byte count.
    logic [63:0] hash_state [8];
    logic [63:0] blk_buf [16];
    logic [6:0]  blk_fill;
    logic [63:0] msg_len;

    digest_exp_t digest_q [$];
    int          errors;
    int          n_items;
    bit          stim_done;
    bit          hold_off;      // long output stall in progress

    // Directed messages: each row is one transaction.
    byte_item_t  dir_tab [$];

    // SHA-512 round constants, kept in the bench.
    logic [63:0] round_k [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    logic [63:0] sha384_init [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

    sha384_hash_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .msg_end    (msg_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digest_word(digest_word),
        .word_last  (word_last)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Run 80 rounds over the block buffer and fold into the chaining words.
    task automatic compress_blk();
        logic [63:0] wv [8];
        logic [63:0] sched [16];
        logic [63:0] t1;
        logic [63:0] t2;
        for (int i = 0; i < 8; i++)
            wv[i] = hash_state[i];
        for (int i = 0; i < 16; i++)
            sched[i] = blk_buf[i];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
                sched[t % 16] = (rotr(sched[(t - 2) % 16], 19) ^ rotr(sched[(t - 2) % 16], 61)
                                 ^ (sched[(t - 2) % 16] >> 6)) + sched[(t - 7) % 16]
                                + (rotr(sched[(t - 15) % 16], 1) ^ rotr(sched[(t - 15) % 16], 8)
                                   ^ (sched[(t - 15) % 16] >> 7)) + sched[t % 16];
            t1 = wv[7] + (rotr(wv[4], 14) ^ rotr(wv[4], 18) ^ rotr(wv[4], 41))
                 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + round_k[t] + sched[t % 16];
            t2 = (rotr(wv[0], 28) ^ rotr(wv[0], 34) ^ rotr(wv[0], 39))
                 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
            wv[7] = wv[6];
            wv[6] = wv[5];
            wv[5] = wv[4];
            wv[4] = wv[3] + t1;
            wv[3] = wv[2];
            wv[2] = wv[1];
            wv[1] = wv[0];
            wv[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += wv[i];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        if (blk_fill[2:0] == 3'd0)
            blk_buf[blk_fill[6:3]] = '0;
        blk_buf[blk_fill[6:3]][56 - 8 * blk_fill[2:0] +: 8] = b;
        blk_fill = blk_fill + 7'd1;
        if (blk_fill == 7'd0)
            compress_blk();
    endtask

    task automatic clear_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = sha384_init[i];
        blk_fill = '0;
        msg_len  = '0;
    endtask

    // Advance the predictor by one accepted transaction; queue the digest on
    // the final one.
    task automatic hash_item(input byte_item_t it);
        logic [63:0] bits;
        if (it.bv)
        begin
            absorb_byte(it.data);
            msg_len++;
        end
        if (it.last)
        begin
            bits = msg_len << 3;
            absorb_byte(8'h80);
            while (blk_fill != 7'd112)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(bits[56 - 8 * i +: 8]);
            for (int i = 0; i < 6; i++)
                digest_q.push_back('{word: hash_state[i], last: (i == 5)});
            clear_hash();
        end
    endtask

    // Offer one transaction, hold it until taken, then feed the predictor.
    // Drop valid only when a gap follows, so valid gets one update per edge.
    task automatic send_item(input byte_item_t it);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= it.data;
        byte_valid <= it.bv;
        msg_end    <= it.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hash_item(it);
        n_items++;
    endtask

    // Output side: random stall, with one long hold-off counted here.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 :
                         ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) == 1) : 1'b1;
    end

    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (3000)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (4000)
            @(posedge clk);
        hold_off = 1'b0;
    end

    // Check each accepted digest word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_q.size() == 0)
            begin
                $display("%0t: unexpected digest word %h", $time, digest_word);
                errors++;
            end
            else
            begin
                if (digest_q[0].word !== digest_word || digest_q[0].last !== word_last)
                begin
                    $display("%0t: expected %h last %b, got %h last %b", $time,
                             digest_q[0].word, digest_q[0].last, digest_word, word_last);
                    errors++;
                end
                void'(digest_q.pop_front());
            end
        end
    end

    // Build one random message; bytes mixed with idle transactions.
    task automatic random_msg(input int len);
        byte_item_t it;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item('{data: 8'($urandom), bv: 1'b0, last: 1'b0});
            it = '{data: 8'($urandom), bv: 1'b1, last: (i == len - 1)};
            send_item(it);
        end
    endtask

    initial
    begin
        int    len;
        errors     = 0;
        n_items    = 0;
        stim_done  = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        byte_valid = 1'b0;
        msg_end    = 1'b0;
        clear_hash();

        // Directed table: empty message, idle then empty, "abc", all-ones
        // byte ending a message, invalid byte with an end flag after data.
        dir_tab = '{
            '{data: 8'h00, bv: 1'b0, last: 1'b1},
            '{data: 8'hff, bv: 1'b0, last: 1'b0},
            '{data: 8'hff, bv: 1'b0, last: 1'b1},
            '{data: 8'h61, bv: 1'b1, last: 1'b0},
            '{data: 8'h62, bv: 1'b1, last: 1'b0},
            '{data: 8'h63, bv: 1'b1, last: 1'b1},
            '{data: 8'hff, bv: 1'b1, last: 1'b1},
            '{data: 8'h00, bv: 1'b1, last: 1'b0},
            '{data: 8'h5a, bv: 1'b0, last: 1'b1}};

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-message digest, typed in from the standard test vector.
        digest_q.push_back('{word: 64'h38b060a751ac9638, last: 1'b0});
        digest_q.push_back('{word: 64'h4cd9327eb1b1e36a, last: 1'b0});
        digest_q.push_back('{word: 64'h21fdb71114be0743, last: 1'b0});
        digest_q.push_back('{word: 64'h4c0cc7bf63f6e1da, last: 1'b0});
        digest_q.push_back('{word: 64'h274edebfe76f65fb, last: 1'b0});
        digest_q.push_back('{word: 64'hd51ad2f14898b95b, last: 1'b1});
        send_item('{data: 8'h00, bv: 1'b0, last: 1'b1});
        // Drop the predictor's copy: the typed-in words stand for it.
        repeat (6)
            void'(digest_q.pop_back());

        foreach (dir_tab[i])
            if (i > 0)
                send_item(dir_tab[i]);

        // Lengths around the one- and two-block padding boundaries.
        random_msg(111);
        random_msg(112);
        random_msg(128);

        // Random messages, mostly short, a few long, up to about 500 items.
        while (n_items < 490)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 260) :
                  $urandom_range(1, 20);
            if (len > 500 - n_items)
                len = 500 - n_items;
            random_msg(len);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Drain, then report once.
    initial
    begin
        wait (stim_done);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        if (errors == 0)
            $display("sha384_hash_engine: match");
        else
            $display("sha384_hash_engine: mismatch");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("sha384_hash_engine: mismatch");
        $finish;
    end

endmodule
